// ===== hdl/dcr_pkg.sv =====
// dcr_pkg: shared types, constants and helpers of the domain centre and radius block
// depends on nothing

package dcr_pkg;

	localparam int MAX_PARTICLES_DEF = 1024;
	localparam int COORD_W = 32;
	localparam int CFG_IDX_W = 4;
	localparam int DVSR_W = 34;
	localparam int MOD_STEPS = 34;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 4'd1;

	localparam logic [COORD_W-1:0] BOX_RESET = 32'd655360;

	typedef struct packed {
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic               has_particle;
		logic               end_of_set;
	} in_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic [COORD_W-1:0] radius;
		logic               set_empty;
	} out_item_t;

	// a zero register means a box of length 2^32
	function automatic logic [COORD_W:0] box_len(input logic [COORD_W-1:0] r);
		box_len = {(r == '0), r};
	endfunction

endpackage

// ===== hdl/dcr_ram.sv =====
// dcr_ram: generic single write, single read ram with registered read data
// depends on nothing

module dcr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/dcr_front.sv =====
// dcr_front: accepts items, writes particles to the store and closes sets
// depends on dcr_pkg

module dcr_front #(
	parameter int MAX_PARTICLES = dcr_pkg::MAX_PARTICLES_DEF,
	parameter int CW = $clog2(MAX_PARTICLES + 1),
	parameter int AW = (MAX_PARTICLES > 1 ? $clog2(MAX_PARTICLES) : 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  dcr_pkg::in_item_t        in_item,
	input  logic [31:0]              box_w,
	input  logic [31:0]              box_h,
	input  logic                     store_busy,
	input  logic                     q_full,
	output logic                     we,
	output logic [AW-1:0]            waddr,
	output logic [63:0]              wdata,
	output logic                     push,
	output logic [CW+63:0]           push_data
);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_next;
	logic          acc;

	assign in_ready  = !store_busy && !q_full;
	assign acc       = in_valid && in_ready;
	assign we        = acc && in_item.has_particle && (cnt_q < CW'(MAX_PARTICLES));
	assign waddr     = cnt_q[AW-1:0];
	assign wdata     = {in_item.pos_x, in_item.pos_y};
	assign cnt_next  = cnt_q + CW'(we);
	assign push      = acc && in_item.end_of_set;
	assign push_data = {cnt_next, box_w, box_h};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			cnt_q <= in_item.end_of_set ? '0 : cnt_next;
		end
	end

endmodule

// ===== hdl/dcr_queue.sv =====
// dcr_queue: two entry queue of closed sets between front and back
// depends on nothing

module dcr_queue #(
	parameter int WIDTH = 75
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty,
	output logic             full
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign dout  = mem_q[rd_ptr_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== hdl/dcr_divider.sv =====
// dcr_divider: bit serial signed by positive division with floor quotient and modulo
// depends on dcr_pkg

module dcr_divider #(
	parameter int NW = 46
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       neg,
	input  logic                       long_op,
	input  logic [NW-1:0]              mag,
	input  logic [dcr_pkg::DVSR_W-1:0] dvsr,
	output logic                       done,
	output logic signed [NW:0]         quo,
	output logic [dcr_pkg::DVSR_W-1:0] md
);

	localparam int RW = dcr_pkg::DVSR_W + 1;
	localparam int SW = $clog2(NW + 1);

	logic                       busy_q;
	logic [SW-1:0]              cnt_q;
	logic [RW-1:0]              rem_q;
	logic [NW-1:0]              sh_q;
	logic                       neg_q;
	logic [dcr_pkg::DVSR_W-1:0] dvsr_q;
	logic [RW-1:0]              trial;
	logic                       ge;
	logic                       rz;
	logic signed [NW:0]         qm;

	assign trial = {rem_q[RW-2:0], sh_q[NW-1]};
	assign ge    = (trial >= {1'b0, dvsr_q});
	assign done  = busy_q && (cnt_q == '0);
	assign rz    = (rem_q == '0);
	assign qm    = {1'b0, sh_q};
	assign quo   = neg_q ? -(qm + (NW+1)'(!rz)) : qm;
	assign md    = (neg_q && !rz) ? dvsr_q - rem_q[RW-2:0] : rem_q[RW-2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			sh_q   <= '0;
			neg_q  <= 1'b0;
			dvsr_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= long_op ? SW'(NW) : SW'(dcr_pkg::MOD_STEPS);
			rem_q  <= '0;
			sh_q   <= long_op ? mag : (mag << (NW - dcr_pkg::MOD_STEPS));
			neg_q  <= neg;
			dvsr_q <= dvsr;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				rem_q <= ge ? trial - {1'b0, dvsr_q} : trial;
				sh_q  <= {sh_q[NW-2:0], ge};
				cnt_q <= cnt_q - SW'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/dcr_back.sv =====
// dcr_back: sequencer for centroid, radius pass and square root of one closed set
// depends on dcr_pkg, dcr_divider

module dcr_back #(
	parameter int MAX_PARTICLES = dcr_pkg::MAX_PARTICLES_DEF,
	parameter int CW = $clog2(MAX_PARTICLES + 1),
	parameter int AW = (MAX_PARTICLES > 1 ? $clog2(MAX_PARTICLES) : 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               pop,
	input  logic [CW+63:0]     job,
	output logic               rd_en,
	output logic [AW-1:0]      raddr,
	input  logic [63:0]        rdata,
	output logic               busy,
	output logic               out_valid,
	input  logic               out_ready,
	output dcr_pkg::out_item_t out_item
);

	localparam int SUM_W = 32 + CW + 1;
	localparam int NW = SUM_W + 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LD0   = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_WT    = 4'd3;
	localparam logic [3:0] ST_MX    = 4'd4;
	localparam logic [3:0] ST_MY    = 4'd5;
	localparam logic [3:0] ST_MEANX = 4'd6;
	localparam logic [3:0] ST_WRAPX = 4'd7;
	localparam logic [3:0] ST_MEANY = 4'd8;
	localparam logic [3:0] ST_WRAPY = 4'd9;
	localparam logic [3:0] ST_MUL   = 4'd10;
	localparam logic [3:0] ST_SQI   = 4'd11;
	localparam logic [3:0] ST_SQRT  = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;

	logic [3:0]              state_q;
	logic                    pass_q;
	logic                    op_q;
	logic [CW-1:0]           n_q;
	logic [CW-1:0]           i_q;
	logic [32:0]             lx_q;
	logic [32:0]             ly_q;
	logic [31:0]             ox_q;
	logic [31:0]             oy_q;
	logic [31:0]             px_q;
	logic [31:0]             py_q;
	logic [31:0]             cx_q;
	logic [31:0]             cy_q;
	logic signed [34:0]      cxr_q;
	logic signed [SUM_W-1:0] sumx_q;
	logic signed [SUM_W-1:0] sumy_q;
	logic [31:0]             ax_q;
	logic [31:0]             ay_q;
	logic [63:0]             p_q;
	logic [63:0]             sqx_q;
	logic [63:0]             max_q;
	logic [1:0]              mc_q;
	logic [63:0]             sv_q;
	logic [63:0]             sres_q;
	logic [63:0]             sbit_q;
	logic [4:0]              scnt_q;
	logic                    empty_q;
	logic                    out_valid_q;
	dcr_pkg::out_item_t      out_item_q;

	logic                       div_start;
	logic                       div_long;
	logic signed [NW:0]         div_sv;
	logic [dcr_pkg::DVSR_W-1:0] div_dvsr;
	logic                       div_neg;
	logic [NW-1:0]              div_mag;
	logic                       div_done;
	logic signed [NW:0]         div_quo;
	logic [dcr_pkg::DVSR_W-1:0] div_md;

	logic signed [NW:0] sx_px, sx_py, sx_ox, sx_oy, sx_cx, sx_cy, sx_n;
	logic signed [NW:0] sx_sumx, sx_sumy, sx_cxr;
	logic [32:0]        cur_l;
	logic signed [34:0] mi;
	logic [34:0]        mi_abs;
	logic [63:0]        d2;
	logic [63:0]        sq_try;
	logic signed [34:0] ox35, oy35;
	logic [CW-1:0]      i_next;

	assign sx_px   = {{(NW-31){1'b0}}, px_q};
	assign sx_py   = {{(NW-31){1'b0}}, py_q};
	assign sx_ox   = {{(NW-31){1'b0}}, ox_q};
	assign sx_oy   = {{(NW-31){1'b0}}, oy_q};
	assign sx_cx   = {{(NW-31){1'b0}}, cx_q};
	assign sx_cy   = {{(NW-31){1'b0}}, cy_q};
	assign sx_n    = {{(NW+1-CW){1'b0}}, n_q};
	assign sx_sumx = {{(NW+1-SUM_W){sumx_q[SUM_W-1]}}, sumx_q};
	assign sx_sumy = {{(NW+1-SUM_W){sumy_q[SUM_W-1]}}, sumy_q};
	assign sx_cxr  = {{(NW-34){cxr_q[34]}}, cxr_q};
	assign ox35    = {3'b000, ox_q};
	assign oy35    = {3'b000, oy_q};
	assign i_next  = i_q + CW'(1);

	always_comb begin
		div_sv   = '0;
		div_dvsr = dcr_pkg::DVSR_W'(lx_q);
		div_long = 1'b0;
		unique case (state_q)
			ST_MX: begin
				div_sv = pass_q ? sx_px - sx_cx : sx_px - sx_ox;
			end
			ST_MY: begin
				div_sv   = pass_q ? sx_py - sx_cy : sx_py - sx_oy;
				div_dvsr = dcr_pkg::DVSR_W'(ly_q);
			end
			ST_MEANX: begin
				div_sv   = (sx_sumx <<< 1) + sx_n;
				div_dvsr = dcr_pkg::DVSR_W'({n_q, 1'b0});
				div_long = 1'b1;
			end
			ST_MEANY: begin
				div_sv   = (sx_sumy <<< 1) + sx_n;
				div_dvsr = dcr_pkg::DVSR_W'({n_q, 1'b0});
				div_long = 1'b1;
			end
			ST_WRAPX: begin
				div_sv = sx_cxr;
			end
			ST_WRAPY: begin
				div_sv   = sx_cxr;
				div_dvsr = dcr_pkg::DVSR_W'(ly_q);
			end
			default: begin
				div_sv = '0;
			end
		endcase
	end

	assign div_neg   = div_sv[NW];
	assign div_mag   = div_neg ? NW'(-div_sv) : NW'(div_sv);
	assign div_start = !op_q && ((state_q == ST_MX) || (state_q == ST_MY) ||
		(state_q == ST_MEANX) || (state_q == ST_MEANY) ||
		(state_q == ST_WRAPX) || (state_q == ST_WRAPY));

	dcr_divider #(.NW(NW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.neg     (div_neg),
		.long_op (div_long),
		.mag     (div_mag),
		.dvsr    (div_dvsr),
		.done    (div_done),
		.quo     (div_quo),
		.md      (div_md)
	);

	// minimum image of the modulo result
	assign cur_l  = (state_q == ST_MY) ? ly_q : lx_q;
	assign mi     = ({div_md, 1'b0} > {2'b00, cur_l}) ?
		$signed({1'b0, div_md}) - $signed({2'b00, cur_l}) : $signed({1'b0, div_md});
	assign mi_abs = mi[34] ? 35'(-mi) : 35'(mi);
	assign d2     = sqx_q + p_q;
	assign sq_try = sres_q + sbit_q;

	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign rd_en     = pop || (state_q == ST_RD);
	assign raddr     = (state_q == ST_RD) ? i_q[AW-1:0] : '0;
	assign busy      = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= 1'b0;
			op_q        <= 1'b0;
			n_q         <= '0;
			i_q         <= '0;
			lx_q        <= '0;
			ly_q        <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			px_q        <= '0;
			py_q        <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			cxr_q       <= '0;
			sumx_q      <= '0;
			sumy_q      <= '0;
			ax_q        <= '0;
			ay_q        <= '0;
			p_q         <= '0;
			sqx_q       <= '0;
			max_q       <= '0;
			mc_q        <= '0;
			sv_q        <= '0;
			sres_q      <= '0;
			sbit_q      <= '0;
			scnt_q      <= '0;
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			if (div_start) begin
				op_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						n_q  <= job[CW+63:64];
						lx_q <= dcr_pkg::box_len(job[63:32]);
						ly_q <= dcr_pkg::box_len(job[31:0]);
						if (job[CW+63:64] == '0) begin
							empty_q <= 1'b1;
							cx_q    <= '0;
							cy_q    <= '0;
							sres_q  <= '0;
							state_q <= ST_OUT;
						end else begin
							empty_q <= 1'b0;
							state_q <= ST_LD0;
						end
					end
				end
				ST_LD0: begin
					ox_q    <= rdata[63:32];
					oy_q    <= rdata[31:0];
					pass_q  <= 1'b0;
					i_q     <= '0;
					sumx_q  <= '0;
					sumy_q  <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_WT;
				end
				ST_WT: begin
					px_q    <= rdata[63:32];
					py_q    <= rdata[31:0];
					state_q <= ST_MX;
				end
				ST_MX: begin
					if (op_q && div_done) begin
						op_q <= 1'b0;
						if (pass_q) begin
							ax_q <= mi_abs[31:0];
						end else begin
							sumx_q <= sumx_q + SUM_W'(mi);
						end
						state_q <= ST_MY;
					end
				end
				ST_MY: begin
					if (op_q && div_done) begin
						op_q <= 1'b0;
						if (pass_q) begin
							ay_q    <= mi_abs[31:0];
							mc_q    <= 2'd0;
							state_q <= ST_MUL;
						end else begin
							sumy_q  <= sumy_q + SUM_W'(mi);
							i_q     <= i_next;
							state_q <= (i_next == n_q) ? ST_MEANX : ST_RD;
						end
					end
				end
				ST_MEANX: begin
					if (op_q && div_done) begin
						op_q    <= 1'b0;
						cxr_q   <= ox35 + $signed(div_quo[34:0]);
						state_q <= ST_WRAPX;
					end
				end
				ST_WRAPX: begin
					if (op_q && div_done) begin
						op_q    <= 1'b0;
						cx_q    <= div_md[31:0];
						state_q <= ST_MEANY;
					end
				end
				ST_MEANY: begin
					if (op_q && div_done) begin
						op_q    <= 1'b0;
						cxr_q   <= oy35 + $signed(div_quo[34:0]);
						state_q <= ST_WRAPY;
					end
				end
				ST_WRAPY: begin
					if (op_q && div_done) begin
						op_q    <= 1'b0;
						cy_q    <= div_md[31:0];
						pass_q  <= 1'b1;
						i_q     <= '0;
						max_q   <= '0;
						state_q <= ST_RD;
					end
				end
				ST_MUL: begin
					unique case (mc_q)
						2'd0: begin
							p_q  <= ax_q * ax_q;
							mc_q <= 2'd1;
						end
						2'd1: begin
							sqx_q <= p_q;
							p_q   <= ay_q * ay_q;
							mc_q  <= 2'd2;
						end
						default: begin
							if (d2 > max_q) begin
								max_q <= d2;
							end
							i_q     <= i_next;
							state_q <= (i_next == n_q) ? ST_SQI : ST_RD;
						end
					endcase
				end
				ST_SQI: begin
					sv_q    <= max_q;
					sres_q  <= '0;
					sbit_q  <= 64'd1 << 62;
					scnt_q  <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sv_q >= sq_try) begin
						sv_q   <= sv_q - sq_try;
						sres_q <= (sres_q >> 1) + sbit_q;
					end else begin
						sres_q <= sres_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
					scnt_q <= scnt_q + 5'd1;
					if (scnt_q == 5'd31) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_item_q.center_x  <= cx_q;
						out_item_q.center_y  <= cy_q;
						out_item_q.radius    <= (sres_q[63:32] != '0) ? 32'hFFFF_FFFF :
							sres_q[31:0];
						out_item_q.set_empty <= empty_q;
						out_valid_q          <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/domain_center_radius_unit.sv =====
// domain_center_radius_unit: top level of the periodic centre and radius block
// depends on dcr_pkg, dcr_ram, dcr_front, dcr_queue, dcr_back
//
// usage
// in channel: one particle per item (has_particle), end_of_set closes the set
// cfg channel: index 0 box_width, index 1 box_height, always ready, write while idle
// out channel: one result per closed set, held in an output register until taken
// particles load into the store at one item per cycle while no closed set is pending
// after the set closes no item is taken until the back end has loaded its result
// back end per set of n particles: a centroid pass over the n particles, the means and
// wraps of both axes, a radius pass and the square root, the divisions all done on the
// shared bit serial divider
// an empty set goes from idle straight to the output register, with no pass
// reset clears the set count and the queue, the box registers return to 10.0
// a stalled receiver holds the result, the back end then waits to load the next result

module domain_center_radius_unit #(
	parameter int MAX_PARTICLES = dcr_pkg::MAX_PARTICLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  dcr_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output dcr_pkg::out_item_t              out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dcr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data
);

	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int AW = (MAX_PARTICLES > 1 ? $clog2(MAX_PARTICLES) : 1);

	logic [31:0]    box_w_q;
	logic [31:0]    box_h_q;
	logic           we;
	logic [AW-1:0]  waddr;
	logic [63:0]    wdata;
	logic           rd_en;
	logic [AW-1:0]  raddr;
	logic [63:0]    rdata;
	logic           push;
	logic           pop;
	logic [CW+63:0] push_data;
	logic [CW+63:0] job;
	logic           q_empty;
	logic           q_full;
	logic           back_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_w_q <= dcr_pkg::BOX_RESET;
			box_h_q <= dcr_pkg::BOX_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == dcr_pkg::REG_BOX_WIDTH) begin
				box_w_q <= cfg_data;
			end
			if (cfg_index == dcr_pkg::REG_BOX_HEIGHT) begin
				box_h_q <= cfg_data;
			end
		end
	end

	dcr_front #(.MAX_PARTICLES(MAX_PARTICLES), .CW(CW), .AW(AW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.box_w      (box_w_q),
		.box_h      (box_h_q),
		.store_busy (!q_empty || back_busy),
		.q_full     (q_full),
		.we         (we),
		.waddr      (waddr),
		.wdata      (wdata),
		.push       (push),
		.push_data  (push_data)
	);

	dcr_ram #(.WIDTH(64), .DEPTH(MAX_PARTICLES)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	dcr_queue #(.WIDTH(CW + 64)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.pop    (pop),
		.dout   (job),
		.empty  (q_empty),
		.full   (q_full)
	);

	dcr_back #(.MAX_PARTICLES(MAX_PARTICLES), .CW(CW), .AW(AW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop       (pop),
		.job       (job),
		.rd_en     (rd_en),
		.raddr     (raddr),
		.rdata     (rdata),
		.busy      (back_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== hdl/dcr_checker.sv =====
// dcr_checker: port level assertions for domain_center_radius_unit, bound to the top level
// depends on dcr_pkg

module dcr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input dcr_pkg::in_item_t             in_item,
	input logic                          out_valid,
	input logic                          out_ready,
	input dcr_pkg::out_item_t            out_item,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [dcr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0]                   cfg_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// empty set reports zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.set_empty |->
		out_item.center_x == '0 && out_item.center_y == '0 && out_item.radius == '0)
		else $error("empty set with non-zero result");

	// store locked after the set closes
	a_lock: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.end_of_set |=> !in_ready)
		else $error("item taken right after end of set");

	// config port never stalls
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind domain_center_radius_unit dcr_checker u_chk (.*);
